// ===== src/bp_pkg.sv =====
// Shared types and constants for the buffer pool with deferred release.
// No dependencies; imported by every module of the block.
`default_nettype none
package bp_pkg;

  localparam int ADDR_W   = 48;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;
  localparam int REL_W    = 6;
  localparam int FAIL_W   = 32;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_HOLD   = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LOC   = 8'b0000_0100,
    S_ALLOC = 8'b0000_1000,
    S_FREE  = 8'b0001_0000,
    S_ROT   = 8'b0010_0000,
    S_RSLOT = 8'b0100_0000,
    S_RPOOL = 8'b1000_0000
  } bp_state_e;

endpackage
`default_nettype wire

// ===== src/bp_locate.sv =====
// Address locate unit: offset from pool base, range and alignment check and
// buffer index, registered the cycle after start. Uses bp_pkg.
`default_nettype none
module bp_locate #(
  parameter int POOL_BUFFERS = 256,
  parameter int BLOCK_BYTES  = 4096
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [bp_pkg::ADDR_W-1:0]      addr_i,
  input  wire  [bp_pkg::ADDR_W-1:0]      base_i,
  output logic                           done_o,
  output logic                           ok_o,
  output logic [$clog2(POOL_BUFFERS)-1:0] idx_o
);
  import bp_pkg::*;

  // block size is a power of two: alignment and index are bit fields of the offset
  localparam int IW = $clog2(POOL_BUFFERS);
  localparam int BW = $clog2(BLOCK_BYTES);
  localparam longint unsigned SPAN = longint'(POOL_BUFFERS) * longint'(BLOCK_BYTES);

  logic [ADDR_W-1:0] off;
  logic              out_range;
  logic              aligned;
  logic              fin_q, ok_q;
  logic [IW-1:0]     idx_q;

  assign off       = addr_i - base_i;
  assign out_range = 64'(off) >= SPAN;
  assign aligned   = off[BW-1:0] == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ok_q  <= !out_range && aligned;
      idx_q <= off[BW +: IW];
    end
  end

  assign done_o = fin_q;
  assign ok_o   = ok_q;
  assign idx_o  = idx_q;

endmodule
`default_nettype wire

// ===== src/buffer_pool_with_deferred_release_unit.sv =====
// Top level of the buffer pool: sequencer, free-list memory, slot memory.
// Depends on bp_pkg and bp_locate.
`default_nettype none
// One command at a time: start is taken while busy is low and each command
// gives one result on the result ports for one cycle, marked by
// result_valid_o; the receiver cannot stall. Commands wait on the registered
// reads of the free-list and slot memories and on the registered address
// locate; a rotate reads every entry of the oldest slot in turn, and a hold
// on a full uplink slot frees its buffer at once if it is in use. BLOCK_BYTES
// must be a power of two. After reset a clearing pass builds the free list;
// busy stays high during it.
module buffer_pool_with_deferred_release_unit #(
  parameter int POOL_BUFFERS  = 256,
  parameter int BLOCK_BYTES   = 4096,
  parameter int DOWN_SLOTS    = 4,
  parameter int UP_SLOTS      = 4,
  parameter int DOWN_PER_SLOT = 32,
  parameter int UP_PER_SLOT   = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  output logic                           busy_o,
  input  wire  [1:0]                     operation_i,
  input  wire                            direction_i,
  input  wire  [bp_pkg::ADDR_W-1:0]      buffer_address_i,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [bp_pkg::ADDR_W-1:0]      cfg_data_i,
  output logic                           result_valid_o,
  output logic [bp_pkg::STATUS_W-1:0]    status_o,
  output logic [bp_pkg::ADDR_W-1:0]      alloc_address_o,
  output logic [bp_pkg::COUNT_W-1:0]     free_count_o,
  output logic [bp_pkg::COUNT_W-1:0]     used_count_o,
  output logic [bp_pkg::REL_W-1:0]       released_count_o,
  output logic [bp_pkg::FAIL_W-1:0]      fail_count_o
);
  import bp_pkg::*;

  localparam int IW    = $clog2(POOL_BUFFERS);
  localparam int CW    = $clog2(POOL_BUFFERS + 1);
  localparam int PW    = IW + 1;
  localparam int DSW   = (DOWN_SLOTS > 1) ? $clog2(DOWN_SLOTS) : 1;
  localparam int USW   = (UP_SLOTS > 1) ? $clog2(UP_SLOTS) : 1;
  localparam int DFW   = $clog2(DOWN_PER_SLOT + 1);
  localparam int UFW   = $clog2(UP_PER_SLOT + 1);
  localparam int FW    = (DFW > UFW) ? DFW : UFW;
  localparam int UBASE = DOWN_SLOTS * DOWN_PER_SLOT;
  localparam int DEPTH = UBASE + UP_SLOTS * UP_PER_SLOT;
  localparam int SAW   = $clog2(DEPTH);

  bp_state_e state_q, state_d;

  logic [ADDR_W-1:0] base_q;
  logic [1:0]        op_q;
  logic              dir_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     top_q, top_d;
  logic [IW-1:0]     clr_q;
  logic [CW-1:0]     free_q, free_d, used_q, used_d;
  logic [FAIL_W-1:0] fail_q, fail_d;
  logic [FW-1:0]     n_q, n_d, i_q, i_d, rel_q, rel_d;

  logic [DFW-1:0] dn_fill_q [DOWN_SLOTS];
  logic [UFW-1:0] up_fill_q [UP_SLOTS];
  logic [DSW-1:0] dn_head_q, dn_new, dn_next;
  logic [USW-1:0] up_head_q, up_new, up_next;
  logic [DSW:0]   dn_sum_new, dn_sum_next;
  logic [USW:0]   up_sum_new, up_sum_next;
  logic           dn_fill_inc, up_fill_inc, dn_rot_done, up_rot_done;

  // free-list memory: {in-use mark, link}
  logic [PW-1:0]  pool_mem [POOL_BUFFERS];
  logic [PW-1:0]  pool_rd_q, pool_wd;
  logic [IW-1:0]  pool_ra, pool_wa;
  logic           pool_re, pool_we;

  logic [IW-1:0]  slot_mem [DEPTH];
  logic [IW-1:0]  slot_rd_q;
  logic [SAW-1:0] slot_ra, slot_wa;
  logic           slot_re, slot_we;

  logic               res_valid_d, res_valid_q;
  logic [STATUS_W-1:0] res_status_d, res_status_q;
  logic [ADDR_W-1:0]  res_addr_d, res_addr_q;
  logic [FW-1:0]      res_rel_d, res_rel_q;

  logic              loc_start, loc_done, loc_ok;
  logic [IW-1:0]     loc_idx;
  logic              accept;
  logic [ADDR_W-1:0] alloc_addr;

  bp_locate #(
    .POOL_BUFFERS(POOL_BUFFERS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_locate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(loc_start),
    .addr_i (buffer_address_i),
    .base_i (base_q),
    .done_o (loc_done),
    .ok_o   (loc_ok),
    .idx_o  (loc_idx)
  );

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  // ring of slots: head is the oldest, the one before it the newest
  assign dn_sum_new  = {1'b0, dn_head_q} + (DSW + 1)'(DOWN_SLOTS - 1);
  assign dn_new      = (dn_sum_new >= (DSW + 1)'(DOWN_SLOTS)) ?
                       DSW'(dn_sum_new - (DSW + 1)'(DOWN_SLOTS)) : DSW'(dn_sum_new);
  assign dn_sum_next = {1'b0, dn_head_q} + (DSW + 1)'(1);
  assign dn_next     = (dn_sum_next >= (DSW + 1)'(DOWN_SLOTS)) ? '0 : DSW'(dn_sum_next);
  assign up_sum_new  = {1'b0, up_head_q} + (USW + 1)'(UP_SLOTS - 1);
  assign up_new      = (up_sum_new >= (USW + 1)'(UP_SLOTS)) ?
                       USW'(up_sum_new - (USW + 1)'(UP_SLOTS)) : USW'(up_sum_new);
  assign up_sum_next = {1'b0, up_head_q} + (USW + 1)'(1);
  assign up_next     = (up_sum_next >= (USW + 1)'(UP_SLOTS)) ? '0 : USW'(up_sum_next);

  assign alloc_addr = base_q + ADDR_W'(longint'(top_q) * longint'(BLOCK_BYTES));

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    top_d        = top_q;
    free_d       = free_q;
    used_d       = used_q;
    fail_d       = fail_q;
    n_d          = n_q;
    i_d          = i_q;
    rel_d        = rel_q;
    pool_re      = 1'b0;
    pool_ra      = idx_q;
    pool_we      = 1'b0;
    pool_wa      = idx_q;
    pool_wd      = {1'b0, top_q};
    slot_re      = 1'b0;
    slot_ra      = '0;
    slot_we      = 1'b0;
    slot_wa      = '0;
    loc_start    = 1'b0;
    dn_fill_inc  = 1'b0;
    up_fill_inc  = 1'b0;
    dn_rot_done  = 1'b0;
    up_rot_done  = 1'b0;
    res_valid_d  = 1'b0;
    res_status_d = ST_OK;
    res_addr_d   = '0;
    res_rel_d    = '0;

    case (state_q)
      S_CLEAR: begin
        pool_we = 1'b1;
        pool_wa = clr_q;
        pool_wd = {1'b0, (clr_q == '0) ? IW'(0) : clr_q - IW'(1)};
        if (clr_q == IW'(POOL_BUFFERS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          case (operation_i)
            OP_ALLOC: begin
              if (free_q == '0) begin
                if (fail_q != '1) fail_d = fail_q + FAIL_W'(1);
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else begin
                pool_re = 1'b1;
                pool_ra = top_q;
                state_d = S_ALLOC;
              end
            end
            OP_ROTATE: begin
              n_d     = direction_i ? FW'(up_fill_q[up_head_q]) : FW'(dn_fill_q[dn_head_q]);
              i_d     = '0;
              rel_d   = '0;
              state_d = S_ROT;
            end
            default: begin
              loc_start = 1'b1;
              state_d   = S_LOC;
            end
          endcase
        end
      end
      S_ALLOC: begin
        top_d      = pool_rd_q[IW-1:0];
        pool_we    = 1'b1;
        pool_wa    = top_q;
        pool_wd    = {1'b1, IW'(0)};
        free_d     = free_q - CW'(1);
        used_d     = used_q + CW'(1);
        res_valid_d = 1'b1;
        res_addr_d  = alloc_addr;
        state_d     = S_IDLE;
      end
      S_LOC: begin
        if (loc_done) begin
          idx_d   = loc_idx;
          state_d = S_IDLE;
          if (!loc_ok) begin
            res_valid_d  = 1'b1;
            res_status_d = ST_BAD_ADDR;
          end else if (op_q == OP_FREE) begin
            pool_re = 1'b1;
            pool_ra = loc_idx;
            state_d = S_FREE;
          end else if (!dir_q) begin
            res_valid_d = 1'b1;
            if (dn_fill_q[dn_new] >= DFW'(DOWN_PER_SLOT)) begin
              res_status_d = ST_DROPPED;
            end else begin
              slot_we     = 1'b1;
              slot_wa     = SAW'(int'(dn_new) * DOWN_PER_SLOT + int'(dn_fill_q[dn_new]));
              dn_fill_inc = 1'b1;
            end
          end else begin
            if (up_fill_q[up_new] >= UFW'(UP_PER_SLOT)) begin
              pool_re = 1'b1;
              pool_ra = loc_idx;
              state_d = S_FREE;
            end else begin
              res_valid_d = 1'b1;
              slot_we     = 1'b1;
              slot_wa     = SAW'(UBASE + int'(up_new) * UP_PER_SLOT + int'(up_fill_q[up_new]));
              up_fill_inc = 1'b1;
            end
          end
        end
      end
      S_FREE: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (!pool_rd_q[IW]) begin
          res_status_d = ST_NOT_USED;
        end else begin
          pool_we = 1'b1;
          top_d   = idx_q;
          free_d  = free_q + CW'(1);
          if (used_q != '0) used_d = used_q - CW'(1);
          if (op_q == OP_HOLD) begin
            res_status_d = ST_RELEASED;
            res_rel_d    = FW'(1);
          end
        end
      end
      S_ROT: begin
        if (i_q < n_q) begin
          slot_re = 1'b1;
          slot_ra = dir_q ? SAW'(UBASE + int'(up_head_q) * UP_PER_SLOT + int'(i_q))
                          : SAW'(int'(dn_head_q) * DOWN_PER_SLOT + int'(i_q));
          state_d = S_RSLOT;
        end else begin
          dn_rot_done = !dir_q;
          up_rot_done = dir_q;
          res_valid_d = 1'b1;
          res_rel_d   = rel_q;
          state_d     = S_IDLE;
        end
      end
      S_RSLOT: begin
        idx_d   = slot_rd_q;
        pool_re = 1'b1;
        pool_ra = slot_rd_q;
        state_d = S_RPOOL;
      end
      S_RPOOL: begin
        // entries held twice are skipped once their buffer is idle
        if (pool_rd_q[IW]) begin
          pool_we = 1'b1;
          top_d   = idx_q;
          free_d  = free_q + CW'(1);
          if (used_q != '0) used_d = used_q - CW'(1);
          rel_d   = rel_q + FW'(1);
        end
        i_d     = i_q + FW'(1);
        state_d = S_ROT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      top_q       <= IW'(POOL_BUFFERS - 1);
      free_q      <= CW'(POOL_BUFFERS);
      used_q      <= '0;
      fail_q      <= '0;
      dn_head_q   <= '0;
      up_head_q   <= '0;
      res_valid_q <= 1'b0;
      for (int k = 0; k < DOWN_SLOTS; k++) dn_fill_q[k] <= '0;
      for (int k = 0; k < UP_SLOTS; k++) up_fill_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      top_q       <= top_d;
      free_q      <= free_d;
      used_q      <= used_d;
      fail_q      <= fail_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + IW'(1);
      if (cfg_valid_i) base_q <= cfg_data_i;
      if (dn_fill_inc) dn_fill_q[dn_new] <= dn_fill_q[dn_new] + DFW'(1);
      if (up_fill_inc) up_fill_q[up_new] <= up_fill_q[up_new] + UFW'(1);
      if (dn_rot_done) begin
        dn_fill_q[dn_head_q] <= '0;
        dn_head_q            <= dn_next;
      end
      if (up_rot_done) begin
        up_fill_q[up_head_q] <= '0;
        up_head_q            <= up_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      dir_q <= direction_i;
    end
    idx_q <= idx_d;
    n_q   <= n_d;
    i_q   <= i_d;
    rel_q <= rel_d;
    if (res_valid_d) begin
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
      res_rel_q    <= res_rel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
    if (pool_re) pool_rd_q <= pool_mem[pool_ra];
  end

  // hold writes the located index, which reaches idx_q only at this edge
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= idx_d;
    if (slot_re) slot_rd_q <= slot_mem[slot_ra];
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_status_q;
  assign alloc_address_o  = res_addr_q;
  assign free_count_o     = COUNT_W'(free_q);
  assign used_count_o     = COUNT_W'(used_q);
  assign released_count_o = REL_W'(res_rel_q);
  assign fail_count_o     = fail_q;

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |-> (32'(free_q) + 32'(used_q) == 32'(POOL_BUFFERS)))
    else $error("free and used counts do not add up to the pool size");

  a_loc_done_in_loc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loc_done |-> (state_q == S_LOC))
    else $error("locate finished outside the locate state");

  a_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> (rel_q <= i_q && i_q <= n_q))
    else $error("rotate walk went past the slot fill");

endmodule
`default_nettype wire

// ===== tb/sv/buffer_pool_with_deferred_release_checker.sv =====
// Checker for the buffer pool: watches commands, config writes and results,
// predicts each result and compares it. Depends on bp_pkg.
`timescale 1ns / 1ps
module buffer_pool_with_deferred_release_checker
  import bp_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire                 busy_i,
  input  wire  [1:0]          operation_i,
  input  wire                 direction_i,
  input  wire  [ADDR_W-1:0]   buffer_address_i,
  input  wire                 cfg_valid_i,
  input  wire                 cfg_ready_i,
  input  wire  [ADDR_W-1:0]   cfg_data_i,
  input  wire                 result_valid_i,
  input  wire  [STATUS_W-1:0] status_i,
  input  wire  [ADDR_W-1:0]   alloc_address_i,
  input  wire  [COUNT_W-1:0]  free_count_i,
  input  wire  [COUNT_W-1:0]  used_count_i,
  input  wire  [REL_W-1:0]    released_count_i,
  input  wire  [FAIL_W-1:0]   fail_count_i,
  output int                  fail_total_o,
  output int                  pending_o,
  output int                  seen_o
);
  localparam int NBUF = 256;
  localparam int BLK  = 4096;
  localparam int NSLOT = 4;
  localparam int PER  = 32;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  nfree;
    logic [COUNT_W-1:0]  nused;
    logic [REL_W-1:0]    nrel;
    logic [FAIL_W-1:0]   nfail;
  } pool_result_t;

  pool_result_t outcome_q[$];

  logic [ADDR_W-1:0] base;
  logic [7:0] link [NBUF];
  int unsigned top;
  bit marked [NBUF];
  int unsigned slot_buf [2][NSLOT][PER];
  int unsigned slot_fill [2][NSLOT];
  int unsigned nfree, nused;
  logic [FAIL_W-1:0] nfail;

  function automatic bit addr_to_index(logic [ADDR_W-1:0] a, output int unsigned idx);
    logic [ADDR_W-1:0] off;
    off = a - base;
    idx = off / BLK;
    return (off < NBUF * BLK) && (off % BLK == 0);
  endfunction

  function automatic bit give_back(int unsigned idx);
    if (!marked[idx]) return 0;
    marked[idx] = 0;
    link[idx] = top[7:0];
    top = idx;
    nfree++;
    if (nused > 0) nused--;
    return 1;
  endfunction

  function automatic pool_result_t pool_step(logic [1:0] op, bit dir, logic [ADDR_W-1:0] a);
    pool_result_t r;
    int unsigned idx, n, freed;
    r = '0;
    case (op)
      OP_ALLOC: begin
        if (nfree == 0) begin
          r.status = ST_EMPTY;
          if (nfail != '1) nfail++;
        end else begin
          idx = top;
          top = link[idx];
          link[idx] = 0;
          marked[idx] = 1;
          nfree--;
          nused++;
          r.addr = base + ADDR_W'(idx) * BLK;
        end
      end
      OP_FREE: begin
        if (!addr_to_index(a, idx)) r.status = ST_BAD_ADDR;
        else if (!give_back(idx)) r.status = ST_NOT_USED;
      end
      OP_HOLD: begin
        n = slot_fill[dir][NSLOT-1];
        if (!addr_to_index(a, idx)) r.status = ST_BAD_ADDR;
        else if (n < PER) begin
          slot_buf[dir][NSLOT-1][n] = idx;
          slot_fill[dir][NSLOT-1] = n + 1;
        end else if (!dir) r.status = ST_DROPPED;
        else if (give_back(idx)) begin
          r.status = ST_RELEASED;
          r.nrel = 1;
        end else r.status = ST_NOT_USED;
      end
      default: begin
        freed = 0;
        for (int i = 0; i < slot_fill[dir][0]; i++)
          if (give_back(slot_buf[dir][0][i])) freed++;
        for (int k = 0; k + 1 < NSLOT; k++) begin
          slot_buf[dir][k] = slot_buf[dir][k+1];
          slot_fill[dir][k] = slot_fill[dir][k+1];
        end
        slot_fill[dir][NSLOT-1] = 0;
        r.nrel = freed;
      end
    endcase
    r.nfree = nfree;
    r.nused = nused;
    r.nfail = nfail;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t got, want;
    if (!rst_ni) begin
      base = '0;
      for (int i = 0; i < NBUF; i++) begin
        link[i] = (i == 0) ? 8'd0 : 8'(i - 1);
        marked[i] = 0;
      end
      top = NBUF - 1;
      slot_fill = '{default: 0};
      nfree = NBUF;
      nused = 0;
      nfail = '0;
      outcome_q.delete();
      fail_total_o <= 0;
      pending_o <= 0;
      seen_o <= 0;
    end else begin
      // result first: a command accepted now cannot have its result this cycle
      if (result_valid_i) begin
        got = '{status_i, alloc_address_i, free_count_i, used_count_i,
                released_count_i, fail_count_i};
        seen_o <= seen_o + 1;
        if (outcome_q.size() == 0) begin
          if (fail_total_o < 10) $display("unexpected result %h", got);
          fail_total_o <= fail_total_o + 1;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            if (fail_total_o < 10) begin
              $display("mismatch: exp st=%0d addr=%h free=%0d used=%0d rel=%0d fail=%0d",
                       want.status, want.addr, want.nfree, want.nused, want.nrel,
                       want.nfail);
              $display("          act st=%0d addr=%h free=%0d used=%0d rel=%0d fail=%0d",
                       got.status, got.addr, got.nfree, got.nused, got.nrel, got.nfail);
            end
            fail_total_o <= fail_total_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) base = cfg_data_i;
      if (start_i && !busy_i)
        outcome_q.push_back(pool_step(operation_i, direction_i, buffer_address_i));
      pending_o <= outcome_q.size();
    end
  end
endmodule

// ===== tb/sv/buffer_pool_with_deferred_release_unit_test.sv =====
// Testbench top for the buffer pool: clock, reset, commands, config writes.
// Depends on bp_pkg, the block and buffer_pool_with_deferred_release_checker.
`timescale 1ns / 1ps
module buffer_pool_with_deferred_release_unit_test;
  import bp_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic start_i = 0, direction_i = 0, cfg_valid_i = 0;
  logic [1:0] operation_i = OP_ALLOC;
  logic [ADDR_W-1:0] buffer_address_i = '0, cfg_data_i = '0;
  logic busy_o, cfg_ready_o, result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [ADDR_W-1:0] alloc_address_o;
  logic [COUNT_W-1:0] free_count_o, used_count_o;
  logic [REL_W-1:0] released_count_o;
  logic [FAIL_W-1:0] fail_count_o;
  int fail_total, pending, seen;
  int unsigned cycles = 0;
  int idle_pct = 0;
  logic [ADDR_W-1:0] cur_base = '0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  buffer_pool_with_deferred_release_unit dut (.*);

  buffer_pool_with_deferred_release_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .direction_i,
    .buffer_address_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .result_valid_i(result_valid_o), .status_i(status_o),
    .alloc_address_i(alloc_address_o), .free_count_i(free_count_o),
    .used_count_i(used_count_o), .released_count_i(released_count_o),
    .fail_count_i(fail_count_o), .fail_total_o(fail_total),
    .pending_o(pending), .seen_o(seen));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one command transaction; start stays high until an idle gap, the next command or a drain
  task automatic issue(logic [1:0] op, bit dir, logic [ADDR_W-1:0] a);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1;
    operation_i <= op;
    direction_i <= dir;
    buffer_address_i <= a;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain;
    start_i <= 0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_base(logic [ADDR_W-1:0] v);
    drain();
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    cur_base = v;
  endtask

  function automatic logic [ADDR_W-1:0] buf_addr(int unsigned i);
    return cur_base + ADDR_W'(i) * 4096;
  endfunction

  // mostly valid buffer addresses, sometimes misaligned or out of range
  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return buf_addr($urandom_range(255));
    if (r < 88) return buf_addr($urandom_range(255)) + $urandom_range(4095, 1);
    if (r < 94) return buf_addr($urandom_range(300, 256));
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) issue(OP_ALLOC, $urandom_range(1), {$urandom, $urandom});
      else if (r < 55) issue(OP_FREE, $urandom_range(1), pick_addr());
      else if (r < 85) issue(OP_HOLD, $urandom_range(1), pick_addr());
      else issue(OP_ROTATE, $urandom_range(1), {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // directed: empty pool, bad addresses, idle free, full slots
    issue(OP_FREE, 0, 48'h0);
    issue(OP_FREE, 0, 48'h1);
    issue(OP_FREE, 0, 48'hFFFF_FFFF_FFFF);
    issue(OP_FREE, 0, 48'h10_0000);
    issue(OP_HOLD, 1, 48'h0);
    issue(OP_HOLD, 0, 48'hFF000);
    issue(OP_ROTATE, 0, '0);
    issue(OP_ROTATE, 1, '0);
    for (int i = 0; i < 258; i++) issue(OP_ALLOC, 0, '0);
    for (int i = 0; i < 34; i++) issue(OP_HOLD, 0, buf_addr(i));
    for (int i = 0; i < 34; i++) issue(OP_HOLD, 1, buf_addr(i + 40));
    for (int i = 0; i < 4; i++) begin
      issue(OP_ROTATE, 0, '0);
      issue(OP_ROTATE, 1, '0);
    end
    set_base(48'hFFFF_FFFF_F000);
    idle_pct = 24;
    random_phase(436);
    set_base(48'h0);
    idle_pct = 48;
    random_phase(436);
    set_base({$urandom, $urandom} & 48'hFFFF_FFFF_F000);
    idle_pct = 0;
    random_phase(218);
    set_base({$urandom, $urandom});
    random_phase(218);
    drain();
    $display("Covered all operations on both slot sets, empty pool, full slots and %0d results",
             seen);
    if (fail_total == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
